### src/dcvp_pkg.sv
// shared types, constants and lookup functions for the vibration pwm node
// no dependencies; compile first
`default_nettype none

package dcvp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 8;
  localparam int unsigned WinW   = 7;
  localparam int unsigned DutyW  = 5;
  localparam int unsigned FreqW  = 2;

  localparam int unsigned PhasePeriodDefault = 200;
  localparam int unsigned QueueDepth         = 2;

  localparam logic [ByteW-1:0]   PeriodReset  = 8'd52;
  localparam logic [2*ByteW-1:0] CompareLow   = 16'd64;
  localparam logic [ByteW-1:0]   AddrStepDown = 8'd2;

  // duty level to on-window length in phase steps
  localparam logic [WinW-1:0] DUTY_TABLE [32] = '{
    7'd0,  7'd0,  7'd0,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,
    7'd7,  7'd8,  7'd10, 7'd13, 7'd15, 7'd18, 7'd20, 7'd23,
    7'd27, 7'd30, 7'd34, 7'd38, 7'd42, 7'd46, 7'd50, 7'd55,
    7'd60, 7'd65, 7'd70, 7'd76, 7'd82, 7'd88, 7'd94, 7'd99
  };

  // what the back end has to do with one beat
  typedef enum logic [2:0] {
    KIND_DROP,
    KIND_TICK,
    KIND_ADDR_FWD,
    KIND_SELECT,
    KIND_STOP,
    KIND_DATA
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             ninth;
  } entry_t;

  function automatic logic [ByteW-1:0] period_lut(input logic [FreqW-1:0] freq);
    logic [ByteW-1:0] p;
    case (freq)
      2'd0:    p = 8'd72;
      2'd1:    p = 8'd52;
      2'd2:    p = 8'd37;
      default: p = 8'd27;
    endcase
    return p;
  endfunction

  function automatic logic parity8(input logic [ByteW-1:0] v);
    return ^v;
  endfunction

endpackage

`default_nettype wire

### src/dcvp_if.sv
// handshake interfaces for the input and result channels
// no dependencies
`default_nettype none

interface dcvp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;
  logic       rx_ninth;

  modport source (output valid, output operation, output rx_byte, output rx_ninth,
                  input ready);
  modport sink   (input valid, input operation, input rx_byte, input rx_ninth,
                  output ready);
endinterface

interface dcvp_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_ninth;
  logic       drive_on;
  logic       bridge_opposed;
  logic       amplitude_full;
  logic [7:0] period_value;
  logic [7:0] compare_high;
  logic [7:0] compare_low;
  logic [4:0] duty_level;

  modport source (output valid, output tx_valid, output tx_byte, output tx_ninth,
                  output drive_on, output bridge_opposed, output amplitude_full,
                  output period_value, output compare_high, output compare_low,
                  output duty_level, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input tx_ninth,
                  input drive_on, input bridge_opposed, input amplitude_full,
                  input period_value, input compare_high, input compare_low,
                  input duty_level, output ready);
endinterface

`default_nettype wire

### src/dcvp_front.sv
// front end: parity check and classification of incoming beats
// depends on dcvp_pkg and dcvp_if
`default_nettype none

module dcvp_front (
  dcvp_in_if.sink          in_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output dcvp_pkg::entry_t push_entry_o
);
  import dcvp_pkg::*;

  logic             parity_ok;
  logic [ByteW-1:0] fwd_byte;

  assign parity_ok = (parity8(in_i.rx_byte) == in_i.rx_ninth);
  // address minus one with start bit kept is the byte minus two
  assign fwd_byte  = in_i.rx_byte - AddrStepDown;

  always_comb begin
    push_entry_o.data  = in_i.rx_byte;
    push_entry_o.ninth = in_i.rx_ninth;
    if (in_i.operation) begin
      push_entry_o.kind = KIND_TICK;
    end else if (!parity_ok) begin
      push_entry_o.kind = KIND_DROP;
    end else if (in_i.rx_byte[ByteW-1]) begin
      push_entry_o.kind = KIND_DATA;
    end else if (in_i.rx_byte[ByteW-2:1] != '0) begin
      push_entry_o.kind  = KIND_ADDR_FWD;
      push_entry_o.data  = fwd_byte;
      push_entry_o.ninth = parity8(fwd_byte);
    end else if (in_i.rx_byte[0]) begin
      push_entry_o.kind = KIND_SELECT;
    end else begin
      push_entry_o.kind = KIND_STOP;
    end
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

`default_nettype wire

### src/dcvp_queue.sv
// short queue of classified beats between front and back end
// depends on dcvp_pkg
`default_nettype none

module dcvp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  dcvp_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output dcvp_pkg::entry_t pop_entry_o
);
  import dcvp_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t          slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue fill beyond depth");
  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill did not grow on push");
`endif

endmodule

`default_nettype wire

### src/dcvp_back.sv
// back end: node state, pwm phase logic and the registered result beat
// depends on dcvp_pkg and dcvp_if
`default_nettype none

module dcvp_back #(
  parameter int unsigned PHASE_PERIOD = dcvp_pkg::PhasePeriodDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  dcvp_pkg::entry_t pop_entry_i,
  dcvp_out_if.source       out_o
);
  import dcvp_pkg::*;

  localparam int unsigned Half = PHASE_PERIOD / 2;

  logic                selected_q, selected_d;
  logic                running_q, running_d;
  logic [DutyW-1:0]    duty_q, duty_d;
  logic [WinW-1:0]     window_q, window_d;
  logic [ByteW-1:0]    period_q, period_d;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic                bridge_q, bridge_d;
  logic                amp_q, amp_d;
  logic [2*ByteW-1:0]  compare_q, compare_d;

  logic                out_valid_q;
  logic                tx_valid_q, tx_valid_d;
  logic [ByteW-1:0]    tx_byte_q, tx_byte_d;
  logic                tx_ninth_q, tx_ninth_d;

  logic                pop;
  logic [PhaseW:0]     ph_inc;
  logic [PhaseW-1:0]   ph_next;
  logic [PhaseW:0]     ph_ext;
  logic [PhaseW:0]     win_ext;
  logic [PhaseW:0]     win_hi;
  logic                in_window;
  logic [DutyW-1:0]    new_duty;

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  // next phase position and window compares
  assign ph_inc    = {1'b0, phase_q} + 1'b1;
  assign ph_next   = (ph_inc >= (PhaseW+1)'(PHASE_PERIOD)) ? '0 : ph_inc[PhaseW-1:0];
  assign ph_ext    = {1'b0, ph_next};
  assign win_ext   = (PhaseW+1)'(window_q);
  assign win_hi    = win_ext + (PhaseW+1)'(Half);
  assign in_window = (ph_ext < win_ext);
  assign new_duty  = pop_entry_i.data[ByteW-2:FreqW];

  always_comb begin
    selected_d = selected_q;
    running_d  = running_q;
    duty_d     = duty_q;
    window_d   = window_q;
    period_d   = period_q;
    phase_d    = phase_q;
    bridge_d   = bridge_q;
    amp_d      = amp_q;
    compare_d  = compare_q;
    tx_valid_d = 1'b0;
    tx_byte_d  = '0;
    tx_ninth_d = 1'b0;
    case (pop_entry_i.kind)
      KIND_TICK: begin
        if (running_q) begin
          phase_d  = ph_next;
          bridge_d = in_window ||
                     ((ph_ext >= (PhaseW+1)'(Half)) && (ph_ext < win_hi));
          if (in_window) begin
            if (!amp_q) begin
              compare_d = {period_q, {ByteW{1'b0}}};
              amp_d     = 1'b1;
            end
          end else if (amp_q) begin
            compare_d = CompareLow;
            amp_d     = 1'b0;
          end
        end
      end
      KIND_ADDR_FWD: begin
        selected_d = 1'b0;
        tx_valid_d = 1'b1;
        tx_byte_d  = pop_entry_i.data;
        tx_ninth_d = pop_entry_i.ninth;
      end
      KIND_SELECT: begin
        selected_d = 1'b1;
      end
      KIND_STOP: begin
        selected_d = 1'b0;
        running_d  = 1'b0;
        duty_d     = '0;
      end
      KIND_DATA: begin
        if (selected_q) begin
          running_d  = 1'b1;
          duty_d     = new_duty;
          window_d   = DUTY_TABLE[new_duty];
          period_d   = period_lut(pop_entry_i.data[FreqW-1:0]);
          selected_d = 1'b0;
        end else begin
          tx_valid_d = 1'b1;
          tx_byte_d  = pop_entry_i.data;
          tx_ninth_d = pop_entry_i.ninth;
        end
      end
      default: begin
        // parity failure: beat gives a result but leaves state alone
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      selected_q  <= 1'b0;
      running_q   <= 1'b0;
      duty_q      <= '0;
      window_q    <= '0;
      period_q    <= PeriodReset;
      phase_q     <= '0;
      bridge_q    <= 1'b0;
      amp_q       <= 1'b0;
      compare_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        selected_q <= selected_d;
        running_q  <= running_d;
        duty_q     <= duty_d;
        window_q   <= window_d;
        period_q   <= period_d;
        phase_q    <= phase_d;
        bridge_q   <= bridge_d;
        amp_q      <= amp_d;
        compare_q  <= compare_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      tx_valid_q <= tx_valid_d;
      tx_byte_q  <= tx_byte_d;
      tx_ninth_q <= tx_ninth_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.tx_valid       = tx_valid_q;
  assign out_o.tx_byte        = tx_byte_q;
  assign out_o.tx_ninth       = tx_ninth_q;
  assign out_o.drive_on       = running_q;
  assign out_o.bridge_opposed = bridge_q;
  assign out_o.amplitude_full = amp_q;
  assign out_o.period_value   = period_q;
  assign out_o.compare_high   = compare_q[2*ByteW-1:ByteW];
  assign out_o.compare_low    = compare_q[ByteW-1:0];
  assign out_o.duty_level     = duty_q;

`ifndef ASSERT_OFF
  a_pop_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_q)
    else $error("popped beat produced no result");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < PhaseW'(PHASE_PERIOD))
    else $error("phase counter out of range");
  a_full_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    amp_q |-> (compare_q[ByteW-1:0] == '0))
    else $error("full amplitude compare has nonzero low byte");
`endif

endmodule

`default_nettype wire

### src/daisy_chain_vibration_pwm_node_unit.sv
// top level of the daisy-chained vibration pwm node
// depends on dcvp_pkg, dcvp_if, dcvp_front, dcvp_queue, dcvp_back
//
// channel | dir | handshake           | payload
// in_i    | in  | valid/ready         | operation, rx_byte, rx_ninth
// out_o   | out | valid/ready         | tx_*, drive_on, bridge_opposed, amplitude_full,
//         |     |                     | period_value, compare_high/low, duty_level
//
// one beat in per cycle while the queue has room, one result beat per input beat
// a beat passes through the queue and then the back-end output register
// the back end updates all node state when it pops a beat
// rst_ni clears node state to its idle values; no clearing pass is needed
// a stalled output holds its beat; the two-entry queue keeps taking input until full
`default_nettype none

module daisy_chain_vibration_pwm_node_unit #(
  parameter int unsigned PHASE_PERIOD = dcvp_pkg::PhasePeriodDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcvp_in_if.sink    in_i,
  dcvp_out_if.source out_o
);
  import dcvp_pkg::*;

  // classified beat from front to queue
  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;

  // queue head toward the back end
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  // parity check and sorting of bytes and ticks
  dcvp_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // decouples input acceptance from result stalls
  dcvp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // selection, drive setup and phase windowing, registered result
  dcvp_back #(
    .PHASE_PERIOD (PHASE_PERIOD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
